/* hdl/tdks_pkg.sv */
package tdks_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int SUM_W   = 34;

   typedef struct packed {
      logic signed [KEY_W-1:0]   item_key;
      logic signed [VALUE_W-1:0] item_value;
      logic                      set_last;
   } req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] best_sum;
      logic                    found;
   } rsp_type;

   // one list entry
   typedef struct packed {
      logic                      used;
      logic [KEY_W-1:0]          key;
      logic signed [VALUE_W-1:0] value;
   } slot_type;

   // what a cell shows its lower neighbor
   typedef struct packed {
      slot_type slot;
      logic     ge;   // used and value >= incoming value
   } link_type;

endpackage

/* hdl/tdks_cell.sv */
module tdks_cell
   import tdks_pkg::*;
#(
   parameter bit FIRST = 1'b0,
   parameter bit LAST  = 1'b0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     enable,
   input  logic     clear,
   input  req_type  pair,
   input  logic     any_match,
   input  link_type up_link,
   input  logic     down_tail,
   output link_type link,
   output logic     match,
   output logic     tail,
   output slot_type slot_next
);

   slot_type slot_ff;
   slot_type slot_in;
   logic     ge;
   logic     hole;
   logic     insert;
   logic     shift;

   assign ge    = slot_ff.used && ($signed(slot_ff.value) >= $signed(pair.item_value));
   assign match = slot_ff.used && (slot_ff.key == $unsigned(pair.item_key));

   // hole: the position the list opens up to (raised entry, first free slot,
   // or the evicted tail entry)
   assign hole = (match && !ge)
              || (!any_match && !slot_ff.used && (FIRST || up_link.slot.used))
              || (!any_match && LAST && slot_ff.used && !ge);

   assign tail   = hole || down_tail;
   assign insert = tail && !ge && (FIRST || up_link.ge);
   assign shift  = tail && !FIRST && !up_link.ge;

   always_comb begin
      slot_in = slot_ff;
      if (insert) begin
         slot_in.used  = 1'b1;
         slot_in.key   = $unsigned(pair.item_key);
         slot_in.value = pair.item_value;
      end else if (shift) begin
         slot_in = up_link.slot;
      end
   end

   // closing pair: the list empties after its sum has been taken
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (enable) begin
         slot_ff <= clear ? '0 : slot_in;
      end
   end

   assign link.slot = slot_ff;
   assign link.ge   = ge;
   assign slot_next = slot_in;

endmodule

/* hdl/tdks_sum_tree.sv */
module tdks_sum_tree
   import tdks_pkg::*;
#(
   parameter int SLOTS = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [SUM_W-1:0] in_values [SLOTS],
   input  logic                    in_found,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rsp_type                 out_payload
);

   localparam int LEVELS = (SLOTS > 1) ? $clog2(SLOTS) : 0;

   logic signed [SUM_W-1:0] data_ff  [LEVELS+1][SLOTS];
   logic                    found_ff [LEVELS+1];
   logic [LEVELS:0]         valid_ff;
   logic [LEVELS:0]         valid_in;
   logic [LEVELS:0]         load;
   logic [LEVELS:0]         go;

   assign go[LEVELS] = valid_ff[LEVELS] && out_ready;
   assign in_ready   = !valid_ff[0] || go[0];
   assign load[0]    = in_valid && in_ready;

   genvar l, j;
   generate
      for (l = 0; l < LEVELS; l++) begin : g_go
         assign go[l]     = valid_ff[l] && (!valid_ff[l+1] || go[l+1]);
         assign load[l+1] = go[l];
      end

      for (l = 0; l <= LEVELS; l++) begin : g_lvl
         assign valid_in[l] = load[l] || (valid_ff[l] && !go[l]);

         if (l == 0) begin : g_first
            always_ff @(posedge clock) begin
               if (load[0]) begin
                  data_ff[0]  <= in_values;
                  found_ff[0] <= in_found;
               end
            end
         end else begin : g_add
            for (j = 0; j < SLOTS; j++) begin : g_pair
               logic signed [SUM_W-1:0] lhs;
               logic signed [SUM_W-1:0] rhs;
               if (2*j < SLOTS) begin : g_l
                  assign lhs = data_ff[l-1][2*j];
               end else begin : g_lz
                  assign lhs = '0;
               end
               if (2*j+1 < SLOTS) begin : g_r
                  assign rhs = data_ff[l-1][2*j+1];
               end else begin : g_rz
                  assign rhs = '0;
               end
               always_ff @(posedge clock) begin
                  if (load[l]) begin
                     data_ff[l][j] <= lhs + rhs;
                  end
               end
            end
            always_ff @(posedge clock) begin
               if (load[l]) begin
                  found_ff[l] <= found_ff[l-1];
               end
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign out_valid            = valid_ff[LEVELS];
   assign out_payload.best_sum = data_ff[LEVELS][0];
   assign out_payload.found    = found_ff[LEVELS];

endmodule

/* hdl/top3_distinct_key_sum_top.sv */
// Top-k distinct key sum. Each req transaction carries a (key, value) pair;
// the block keeps the SLOTS best per-key maxima in a row of cells sorted by
// value, largest first. A known key raises its entry when the new value is
// larger; a new key takes a free slot or evicts the smallest entry when its
// value is strictly larger. The transaction with set_last high is applied
// first, then one rsp transaction returns best_sum (sum of the listed values,
// 34-bit two's complement, which can wrap above four slots) and found (all
// SLOTS slots filled; best_sum is 0 when not), and the list is cleared for
// the next set. Throughput is one pair per clock, but a set_last pair can be
// held back as below: every cell compares the broadcast pair in parallel and
// takes either the pair, its upper neighbor's entry or keeps its own. Results
// come out of an adder tree with clog2(SLOTS)+1 register stages; the edge that
// accepts the last pair loads the entry stage, each stage moves its sums on as
// the next one frees up, and the last stage drives rsp_valid. While rsp is
// stalled the block still takes pairs; only a set_last transaction waits, and
// only when the tree's entry stage is full.
module top3_distinct_key_sum_top
   import tdks_pkg::*;
#(
   parameter int SLOTS = 3
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic                    fire;
   logic                    snap_ready;
   logic                    any_match;
   logic                    full;
   logic [SLOTS-1:0]        match;
   logic [SLOTS-1:0]        used_next;
   logic [SLOTS:0]          tail;
   link_type                link      [SLOTS];
   slot_type                slot_next [SLOTS];
   logic signed [SUM_W-1:0] snap_values [SLOTS];

   // A plain pair never needs the tree; a closing pair needs its entry stage.
   assign req_ready = !req_payload.set_last || snap_ready;
   assign fire      = req_valid && req_ready;
   assign any_match = |match;
   assign tail[SLOTS] = 1'b0;

   genvar i;
   generate
      for (i = 0; i < SLOTS; i++) begin : g_cell
         link_type up_link;
         if (i == 0) begin : g_top
            assign up_link = '0;
         end else begin : g_mid
            assign up_link = link[i-1];
         end

         tdks_cell #(
            .FIRST (i == 0),
            .LAST  (i == SLOTS - 1)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .enable    (fire),
            .clear     (req_payload.set_last),
            .pair      (req_payload),
            .any_match (any_match),
            .up_link   (up_link),
            .down_tail (tail[i+1]),
            .link      (link[i]),
            .match     (match[i]),
            .tail      (tail[i]),
            .slot_next (slot_next[i])
         );

         assign used_next[i] = slot_next[i].used;
         // the sum only counts when the list is full
         assign snap_values[i] = full ? SUM_W'(slot_next[i].value) : '0;
      end
   endgenerate

   assign full = &used_next;

   tdks_sum_tree #(
      .SLOTS (SLOTS)
   ) u_sum_tree (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (fire && req_payload.set_last),
      .in_ready    (snap_ready),
      .in_values   (snap_values),
      .in_found    (full),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_payload (rsp_payload)
   );

endmodule
